[rtl/udpf_pkg.sv]
package udpf_pkg;

	localparam int MAX_PACKET_BYTES = 8;
	localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);

	localparam logic [7:0]  SYNC_BYTE = 8'h80;
	localparam logic [7:0]  PID_DATA0 = 8'hC3;
	localparam logic [7:0]  PID_DATA1 = 8'h4B;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// one accepted byte, expanded into what the serializer sends
	typedef struct packed {
		logic        has_head;  // sync + PID go first
		logic [7:0]  pid;
		logic [7:0]  data;
		logic        has_crc;   // packet closes after this byte
		logic [15:0] crc;       // already inverted
	} burst_t;

	typedef enum logic [2:0] {
		STEP_SYNC,
		STEP_PID,
		STEP_DATA,
		STEP_CRC_LO,
		STEP_CRC_HI
	} step_t;

	// reflected CRC16, one byte, LSB first
	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/udpf_if.sv]
interface udpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       final_byte;

	modport source (output valid, output payload_byte, output final_byte, input ready);
	modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface udpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;
	logic       packet_end;
	logic       run_last;

	modport source (output valid, output wire_byte, output packet_end, output run_last,
		input ready);
	modport sink   (input valid, input wire_byte, input packet_end, input run_last,
		output ready);
endinterface

[rtl/udpf_framer.sv]
module udpf_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        payload_byte,
	input  logic              final_byte,
	output udpf_pkg::burst_t  burst
);
	import udpf_pkg::*;

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] count_q;
	logic             data1_q;

	logic             open;
	logic             close;
	logic [15:0]      crc_next;

	assign open     = (count_q == '0);
	assign crc_next = crc_add_byte(open ? CRC_INIT : crc_q, payload_byte);
	assign close    = final_byte || (count_q == CNT_W'(MAX_PACKET_BYTES - 1));

	always_comb begin
		burst.has_head = open;
		burst.pid      = data1_q ? PID_DATA1 : PID_DATA0;
		burst.data     = payload_byte;
		burst.has_crc  = close;
		burst.crc      = ~crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
			data1_q <= 1'b1;
		end else if (accept) begin
			if (close) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
			end else begin
				crc_q   <= crc_next;
				count_q <= count_q + CNT_W'(1);
			end
			// end of transfer restarts at DATA1
			if (final_byte) begin
				data1_q <= 1'b1;
			end else if (open) begin
				data1_q <= ~data1_q;
			end
		end
	end

endmodule

[rtl/udpf_serializer.sv]
module udpf_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  udpf_pkg::burst_t  burst,
	output logic              take,
	udpf_out_if.source        packet
);
	import udpf_pkg::*;

	burst_t burst_q;
	step_t  step_q;
	step_t  step_next;
	logic   valid_q;
	logic   is_last;

	// next state
	always_comb begin
		step_next = step_q;
		unique case (step_q)
			STEP_SYNC:   step_next = STEP_PID;
			STEP_PID:    step_next = STEP_DATA;
			STEP_DATA:   step_next = STEP_CRC_LO;
			STEP_CRC_LO: step_next = STEP_CRC_HI;
			STEP_CRC_HI: step_next = STEP_CRC_HI;
			default:     step_next = STEP_DATA;
		endcase
	end

	// outputs
	always_comb begin
		packet.wire_byte  = burst_q.data;
		packet.packet_end = 1'b0;
		is_last           = 1'b0;
		unique case (step_q)
			STEP_SYNC:   packet.wire_byte = SYNC_BYTE;
			STEP_PID:    packet.wire_byte = burst_q.pid;
			STEP_DATA: begin
				packet.wire_byte = burst_q.data;
				is_last          = !burst_q.has_crc;
			end
			STEP_CRC_LO: packet.wire_byte = burst_q.crc[7:0];
			STEP_CRC_HI: begin
				packet.wire_byte  = burst_q.crc[15:8];
				packet.packet_end = 1'b1;
				is_last           = 1'b1;
			end
			default:     packet.wire_byte = burst_q.data;
		endcase
	end

	assign packet.run_last = is_last;
	assign packet.valid    = valid_q;
	assign take            = !valid_q || (packet.ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= STEP_DATA;
		end else if (load) begin
			valid_q <= 1'b1;
			step_q  <= burst.has_head ? STEP_SYNC : STEP_DATA;
		end else if (valid_q && packet.ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				step_q <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
	end

endmodule

[rtl/usb_data_packet_framer_top.sv]
// USB data packet framer: payload bytes in, sync/PID/payload/CRC16 bytes out.
// The first byte of a request is on the output in the cycle after accept.
// Output: one byte per cycle while packet.ready is high; a request makes 1 to 5
//   bytes on the single output byte lane (3 when a packet opens, +2 on close).
// Reset (async, active low): CRC 0xFFFF, empty packet, DATA1 next, output idle.
module usb_data_packet_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	udpf_in_if.sink     payload,
	udpf_out_if.source  packet
);
	import udpf_pkg::*;

	// burst of the byte on the input, built against the current packet state
	burst_t burst;
	logic   take;
	logic   accept;

	// a new request loads as the last byte of the previous one leaves,
	// so back-to-back requests keep the output lane busy every cycle
	assign payload.ready = take;
	assign accept        = payload.valid && take;

	// packet state and CRC16: one byte folded in per accepted request
	udpf_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.payload_byte (payload.payload_byte),
		.final_byte   (payload.final_byte),
		.burst        (burst)
	);

	// holds the burst and sends its bytes one per cycle while packet.ready is high
	udpf_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.burst  (burst),
		.take   (take),
		.packet (packet)
	);

endmodule

[tb/tb_top.sv]
module tb_top;
	import udpf_pkg::*;

	// One byte on the packet side, as the checker sees it.
	typedef struct packed {
		logic [7:0] wire_byte;
		logic       packet_end;
		logic       run_last;
	} wire_out_t;

	// Packet framing predictor plus the queue of bytes still owed by the block.
	// State mirrors the framer: CRC of the open packet, payload bytes in it, next PID.
	class packet_scoreboard;
		wire_out_t   owed_q[$];
		logic [15:0] crc;
		int unsigned fill;
		bit          next_data1;
		int unsigned errors;

		function new();
			crc        = CRC_INIT;
			fill       = 0;
			next_data1 = 1'b1;
			errors     = 0;
		endfunction

		// reflected CRC16, bit at a time, LSB first
		function logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = c;
			for (int i = 0; i < 8; i++) begin
				fb = r[0] ^ b[i];
				r  = r >> 1;
				if (fb) begin
					r = r ^ CRC_POLY;
				end
			end
			return r;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Accepted request: work out the 1 to 5 wire bytes it causes.
		function void note_request(logic [7:0] b, logic last_flag);
			wire_out_t   burst[$];
			logic [15:0] sent;
			if (fill == 0) begin
				burst.push_back('{SYNC_BYTE, 1'b0, 1'b0});
				burst.push_back('{next_data1 ? PID_DATA1 : PID_DATA0, 1'b0, 1'b0});
				next_data1 = !next_data1;
				crc        = CRC_INIT;
			end
			burst.push_back('{b, 1'b0, 1'b0});
			crc  = crc16_fold(crc, b);
			fill = fill + 1;
			if (last_flag || fill >= MAX_PACKET_BYTES) begin
				sent = ~crc;
				burst.push_back('{sent[7:0], 1'b0, 1'b0});
				burst.push_back('{sent[15:8], 1'b1, 1'b0});
				fill = 0;
				crc  = CRC_INIT;
				if (last_flag) begin
					next_data1 = 1'b1;
				end
			end
			burst[burst.size() - 1].run_last = 1'b1;
			foreach (burst[i]) begin
				owed_q.push_back(burst[i]);
			end
		endfunction

		task report(string what);
			if (errors < 50) begin
				$display("%0t mismatch: %s", $time, what);
			end
			errors++;
		endtask

		task check_result(logic [7:0] wb, logic pe, logic rl);
			wire_out_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("byte %h with nothing pending", wb));
			end else begin
				want = owed_q.pop_front();
				if (wb !== want.wire_byte) begin
					report($sformatf("wire_byte got %h want %h", wb, want.wire_byte));
				end
				if (pe !== want.packet_end) begin
					report($sformatf("packet_end got %b want %b", pe, want.packet_end));
				end
				if (rl !== want.run_last) begin
					report($sformatf("run_last got %b want %b", rl, want.run_last));
				end
			end
		endtask
	endclass

	localparam int STALL_LIMIT = 1000; // cycles with no handshake on either side
	localparam int TAIL_CYCLES = 30;   // quiet time after the last owed byte
	localparam int REQ_TARGET  = 330;

	logic clk;
	logic arst_n;

	udpf_in_if  req_if ();
	udpf_out_if frame_if ();

	packet_scoreboard sb = new();

	// runs of back-to-back traffic, one counter per side
	int calm_req;
	int calm_out;
	int idle_cycles;

	usb_data_packet_framer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(req_if),
		.packet (frame_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap before the next request/response: mostly 0..11, with calm
	// stretches where the side never idles.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// Present one request and hold it until the framer takes it.
	// valid is only lowered when a gap follows, so it is never dropped and
	// raised again in the same step.
	task automatic send_request(input logic [7:0] b, input logic last_flag);
		int gap;
		gap = draw_gap(calm_req);
		if (gap > 0) begin
			req_if.valid        <= 1'b0;
			req_if.payload_byte <= 8'($urandom);  // junk while idle
			req_if.final_byte   <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.payload_byte <= b;
		req_if.final_byte   <= last_flag;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(b, last_flag);
	endtask

	// Hold off new requests until every owed byte has come out.
	task automatic drain_pause();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls on ready, every accepted byte goes to the checker.
	initial begin
		frame_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int gap;
			gap = draw_gap(calm_out);
			if (gap > 0) begin
				frame_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			frame_if.ready <= 1'b1;
			do @(posedge clk); while (!frame_if.valid);
			sb.check_result(frame_if.wire_byte, frame_if.packet_end, frame_if.run_last);
		end
	end

	// Watchdog: a hung handshake on both sides ends the run.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req_if.valid && req_if.ready) || (frame_if.valid && frame_if.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int len;
		int pick;
		logic [7:0] b;

		calm_req            = 0;
		calm_out            = 0;
		idle_cycles         = 0;
		arst_n              <= 1'b0;
		req_if.valid        <= 1'b0;
		req_if.payload_byte <= 8'h00;
		req_if.final_byte   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// one-byte transfers at both data extremes: DATA1 each time
		send_request(8'h00, 1'b1);
		send_request(8'hFF, 1'b1);
		// exactly full packet with the last flag on byte 8: one close, no null packet
		for (int i = 0; i < 8; i++) begin
			send_request(8'h01 << i, i == 7);
		end
		// full packet without the flag, then two more: DATA1 then DATA0
		for (int i = 0; i < 10; i++) begin
			send_request(~(8'h01 << (i % 8)), i == 9);
		end
		// short transfer right after, PID back to DATA1
		send_request(8'h7F, 1'b0);
		send_request(8'h80, 1'b1);

		// sender holds off until the framer has caught up
		drain_pause();

		// --- random transfers ---
		// lengths biased toward packet boundaries: 1..3, multiples of 8,
		// one off a multiple of 8, and anything up to 3 packets
		sent = 0;
		while (sent < REQ_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				len = $urandom_range(1, 3);
			end else if (pick < 5) begin
				len = 8 * $urandom_range(1, 3);
			end else if (pick < 6) begin
				len = 8 * $urandom_range(1, 2) + ($urandom_range(0, 1) ? 1 : -1);
			end else begin
				len = $urandom_range(1, 24);
			end
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					b = 8'h00;
				end else if (pick == 1) begin
					b = 8'hFF;
				end else begin
					b = 8'($urandom);
				end
				send_request(b, i == len - 1);
			end
			sent += len;
			if ($urandom_range(0, 7) == 0) begin
				drain_pause();
			end
		end

		// --- wind down ---
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		// stray bytes after this point show up as unexpected in the checker
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
